FILE: rtl/ehb_npm_pkg.sv
package ehb_npm_pkg;

    // operation codes of an input beat
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    // distances are in units of 1/225 (channels count 0..15 as 0..1)
    localparam logic [9:0] LIMIT_DIST    = 10'd225;
    localparam logic [9:0] NO_MATCH_DIST = 10'd675;

    // candidate tag that travels with a palette read
    typedef struct packed {
        logic       vld;
        logic       half;
        logic [4:0] slot;
    } t_tag;

    // scored candidate, also used for the running best (vld = found)
    typedef struct packed {
        logic       vld;
        logic       half;
        logic [4:0] slot;
        logic [3:0] red;
        logic [3:0] green;
        logic [3:0] blue;
        logic [9:0] sq_dist;
    } t_cand;

endpackage

FILE: rtl/ehb_npm_dist.sv
module ehb_npm_dist
    import ehb_npm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tag        i_tag,
    input  logic [11:0] i_word,
    input  logic [3:0]  i_pix_red,
    input  logic [3:0]  i_pix_green,
    input  logic [3:0]  i_pix_blue,
    output t_cand       o_cand
);

    function automatic logic [7:0] sq_diff(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 8'(d) * 8'(d);
    endfunction

    logic [3:0] c_red;
    logic [3:0] c_green;
    logic [3:0] c_blue;
    logic [9:0] c_dist;
    t_cand      r_cand;

    // half-brite candidate: each channel shifted right by one
    assign c_red   = i_word[3:0]  >> i_tag.half;
    assign c_green = i_word[7:4]  >> i_tag.half;
    assign c_blue  = i_word[11:8] >> i_tag.half;

    assign c_dist = 10'(sq_diff(i_pix_red, c_red))
                  + 10'(sq_diff(i_pix_green, c_green))
                  + 10'(sq_diff(i_pix_blue, c_blue));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
        end else begin
            r_cand <= '{vld:     i_tag.vld,
                        half:    i_tag.half,
                        slot:    i_tag.slot,
                        red:     c_red,
                        green:   c_green,
                        blue:    c_blue,
                        sq_dist: c_dist};
        end
    end

    assign o_cand = r_cand;

endmodule

FILE: rtl/ehb_npm_best.sv
module ehb_npm_best
    import ehb_npm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_clear,
    input  t_cand i_cand,
    output t_cand o_best
);

    t_cand r_best;

    // strict less-than: the first minimum in scan order is kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '{vld: 1'b0, half: 1'b0, slot: '0, red: '0, green: '0,
                        blue: '0, sq_dist: LIMIT_DIST};
        end else if (i_clear) begin
            r_best <= '{vld: 1'b0, half: 1'b0, slot: '0, red: '0, green: '0,
                        blue: '0, sq_dist: LIMIT_DIST};
        end else if (i_cand.vld && (i_cand.sq_dist < r_best.sq_dist)) begin
            // vld of the candidate is set here, so it doubles as found
            r_best <= i_cand;
        end
    end

    assign o_best = r_best;

endmodule

FILE: rtl/ehb_nearest_palette_mapper.sv
// Nearest-color palette mapper with extra half-brite candidates.
//
// Input channel (i_valid / o_stall): a beat with operation = load writes
// i_entry_color into palette slot i_entry_slot (slots at or beyond
// PALETTE_ENTRIES are dropped) and gives no result.
// A beat with operation = map searches all entries at full brightness, then
// all entries halved, and returns one result beat on the output channel
// (o_valid / i_stall) with the nearest color below distance 225, if any.
// Every entry must be loaded once after reset before the first map beat;
// the palette RAM is not cleared.
//
// A map beat is scored one candidate per cycle by a single shared
// distance unit fed from the palette RAM read port; the sequencer then drains
// the read and distance registers and moves the best into the output register
// once that register is free. o_stall is high from the scan until the return
// to idle, so no beat of either kind is taken while a map beat is in progress.
// The output register decouples the sides: load beats are taken while a
// result waits; a finished search holds until the receiver drops i_stall.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and
// empties the output register; palette contents are kept as they are.
module ehb_nearest_palette_mapper
    import ehb_npm_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [4:0]  i_entry_slot,
    input  logic [11:0] i_entry_color,
    input  logic [3:0]  i_pixel_red,
    input  logic [3:0]  i_pixel_green,
    input  logic [3:0]  i_pixel_blue,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_out_red,
    output logic [3:0]  o_out_green,
    output logic [3:0]  o_out_blue,
    output logic        o_half_bright,
    output logic [4:0]  o_chosen_slot,
    output logic        o_matched,
    output logic [9:0]  o_best_distance
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_half, n_half;

    // palette RAM and its registered read port
    logic [11:0]      mem [PALETTE_ENTRIES];
    logic [11:0]      r_rd_word;
    t_tag             r_rd_tag;

    // pixel under search
    logic [3:0]       r_pix_red;
    logic [3:0]       r_pix_green;
    logic [3:0]       r_pix_blue;

    t_cand            cand;
    t_cand            best;

    // output register
    logic             r_out_vld;
    logic [3:0]       r_out_red;
    logic [3:0]       r_out_green;
    logic [3:0]       r_out_blue;
    logic             r_out_half;
    logic [4:0]       r_out_slot;
    logic             r_out_matched;
    logic [9:0]       r_out_dist;

    logic             accept;
    logic             map_start;
    logic             load_wr;
    logic [6:0]       slot_ext;
    logic             out_load;

    assign o_stall   = (r_state != S_IDLE);
    assign accept    = i_valid && !o_stall;
    assign map_start = accept && (i_operation == OP_MAP);
    assign slot_ext  = 7'(i_entry_slot);
    assign load_wr   = accept && (i_operation == OP_LOAD)
                     && (slot_ext < 7'(PALETTE_ENTRIES));
    // result moves to the output register once that register is free
    assign out_load  = (r_state == S_DONE) && (!r_out_vld || !i_stall);

    // sequencer: full pass over the palette, then the half-brite pass
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_half  = r_half;
        case (r_state)
            S_IDLE: begin
                if (map_start) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                    n_half  = 1'b0;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_idx = '0;
                    if (r_half) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_half = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                // wait until the read and distance stages are empty
                if (!r_rd_tag.vld && !cand.vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_half   <= 1'b0;
            r_rd_tag <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_half   <= n_half;
            r_rd_tag <= '{vld: (r_state == S_SCAN), half: r_half, slot: 5'(r_idx)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            mem[slot_ext[IDX_W-1:0]] <= i_entry_color;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_word <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (map_start) begin
            r_pix_red   <= i_pixel_red;
            r_pix_green <= i_pixel_green;
            r_pix_blue  <= i_pixel_blue;
        end
    end

    ehb_npm_dist u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (r_rd_tag),
        .i_word      (r_rd_word),
        .i_pix_red   (r_pix_red),
        .i_pix_green (r_pix_green),
        .i_pix_blue  (r_pix_blue),
        .o_cand      (cand)
    );

    ehb_npm_best u_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (map_start),
        .i_cand  (cand),
        .o_best  (best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // best fields are zero when nothing matched; only the distance differs
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_red     <= best.red;
            r_out_green   <= best.green;
            r_out_blue    <= best.blue;
            r_out_half    <= best.half;
            r_out_slot    <= best.slot;
            r_out_matched <= best.vld;
            r_out_dist    <= best.vld ? best.sq_dist : NO_MATCH_DIST;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_out_red       = r_out_red;
    assign o_out_green     = r_out_green;
    assign o_out_blue      = r_out_blue;
    assign o_half_bright   = r_out_half;
    assign o_chosen_slot   = r_out_slot;
    assign o_matched       = r_out_matched;
    assign o_best_distance = r_out_dist;

    a_map_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_start |=> (r_state == S_SCAN))
        else $error("map beat did not start a scan");

    a_done_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_rd_tag.vld && !cand.vld))
        else $error("result taken while candidates in flight");

    a_no_match_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_matched) |->
            ((o_best_distance == NO_MATCH_DIST) && (o_chosen_slot == '0)
             && !o_half_bright))
        else $error("unmatched result carries candidate fields");

    a_match_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_matched) |-> (o_best_distance < LIMIT_DIST))
        else $error("matched result not below limit");

    a_rd_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_tag.vld |-> $past(r_state == S_SCAN))
        else $error("palette read issued outside scan");

endmodule

FILE: verif/tb_ehb_nearest_palette_mapper.sv
module tb_ehb_nearest_palette_mapper
    import ehb_npm_pkg::*;
();

    localparam int PAL_SIZE       = 32;
    localparam int SEARCH_CYCLES  = 2 * PAL_SIZE + 5;   // settling wait before the verdict
    localparam int LONG_HOLD      = 600;                // receiver hold-off for the backpressure test
    localparam int WATCHDOG_LIMIT = 4000;               // cycles without any accepted beat

    // one expected result beat
    typedef struct packed {
        logic [3:0] red;
        logic [3:0] green;
        logic [3:0] blue;
        logic       half;
        logic [4:0] slot;
        logic       matched;
        logic [9:0] sq_dist;
    } t_quantized;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        i_operation   = OP_LOAD;
    logic [4:0]  i_entry_slot  = '0;
    logic [11:0] i_entry_color = '0;
    logic [3:0]  i_pixel_red   = '0;
    logic [3:0]  i_pixel_green = '0;
    logic [3:0]  i_pixel_blue  = '0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_out_red;
    logic [3:0]  o_out_green;
    logic [3:0]  o_out_blue;
    logic        o_half_bright;
    logic [4:0]  o_chosen_slot;
    logic        o_matched;
    logic [9:0]  o_best_distance;

    // predictor state: shadow of the palette RAM and the results still owed
    logic [11:0] palette_shadow [PAL_SIZE];
    t_quantized  pending_colors [$];

    int error_count    = 0;
    int src_idle_pct   = 0;     // chance that the sender skips a cycle
    int sink_stall_pct = 0;     // chance that the receiver stalls a cycle
    bit hold_request   = 1'b0;  // asks the receiver for one long hold-off
    int hold_left      = 0;

    ehb_nearest_palette_mapper #(
        .PALETTE_ENTRIES(PAL_SIZE)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_entry_slot   (i_entry_slot),
        .i_entry_color  (i_entry_color),
        .i_pixel_red    (i_pixel_red),
        .i_pixel_green  (i_pixel_green),
        .i_pixel_blue   (i_pixel_blue),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_half_bright  (o_half_bright),
        .o_chosen_slot  (o_chosen_slot),
        .o_matched      (o_matched),
        .o_best_distance(o_best_distance)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Nearest color over 64 candidates: full brightness slots first, then the
    // same slots halved. Strict less-than against a running best that starts
    // at the 1.0 limit, so the earliest of equal distances wins.
    function automatic t_quantized nearest_color(logic [3:0] pr, logic [3:0] pg,
                                                 logic [3:0] pb);
        t_quantized  best;
        int unsigned low_sq;
        int unsigned d;
        int          idx;
        logic        h;
        logic [11:0] w;
        logic [3:0]  cr;
        logic [3:0]  cg;
        logic [3:0]  cb;
        best   = '0;
        low_sq = LIMIT_DIST;
        for (int c = 0; c < 2 * PAL_SIZE; c++) begin
            h   = (c >= PAL_SIZE);
            idx = h ? c - PAL_SIZE : c;
            w   = palette_shadow[idx];
            cr  = w[3:0] >> h;
            cg  = w[7:4] >> h;
            cb  = w[11:8] >> h;
            d   = (int'(pr) - int'(cr)) * (int'(pr) - int'(cr))
                + (int'(pg) - int'(cg)) * (int'(pg) - int'(cg))
                + (int'(pb) - int'(cb)) * (int'(pb) - int'(cb));
            if (d < low_sq) begin
                low_sq       = d;
                best.red     = cr;
                best.green   = cg;
                best.blue    = cb;
                best.half    = h;
                best.slot    = idx[4:0];
                best.matched = 1'b1;
            end
        end
        // no match leaves colors, half and slot at zero
        best.sq_dist = best.matched ? low_sq[9:0] : NO_MATCH_DIST;
        return best;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Input side. The task is entered at a rising edge; it idles at random,
    // presents the beat and returns at the edge where the beat is taken, so
    // the next call can put up the next beat in the same step.
    // ------------------------------------------------------------------
    task automatic send_beat(logic op, logic [4:0] slot, logic [11:0] color,
                             logic [3:0] pr, logic [3:0] pg, logic [3:0] pb);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_entry_slot  <= slot;
        i_entry_color <= color;
        i_pixel_red   <= pr;
        i_pixel_green <= pg;
        i_pixel_blue  <= pb;
        do @(posedge i_clk); while (o_stall);
        // beat accepted at this edge: update the shadow or predict the result
        if (op == OP_LOAD)
            palette_shadow[slot] = color;
        else
            pending_colors.push_back(nearest_color(pr, pg, pb));
    endtask

    // pixel fields are don't-care on a load beat, slot and color on a map beat
    task automatic load_entry(logic [4:0] slot, logic [11:0] color);
        send_beat(OP_LOAD, slot, color, 4'($urandom), 4'($urandom), 4'($urandom));
    endtask

    task automatic map_pixel(logic [3:0] pr, logic [3:0] pg, logic [3:0] pb);
        send_beat(OP_MAP, 5'($urandom), 12'($urandom), pr, pg, pb);
    endtask

    // ------------------------------------------------------------------
    // Output side: checks each taken result beat against the oldest
    // prediction, then decides the stall for the next cycle.
    // ------------------------------------------------------------------
    task automatic check_result();
        t_quantized want;
        if (pending_colors.size() == 0) begin
            flag_mismatch("result beat with nothing pending, slot", o_chosen_slot, 0);
            return;
        end
        want = pending_colors.pop_front();
        if (o_out_red != want.red)
            flag_mismatch("out_red", o_out_red, want.red);
        if (o_out_green != want.green)
            flag_mismatch("out_green", o_out_green, want.green);
        if (o_out_blue != want.blue)
            flag_mismatch("out_blue", o_out_blue, want.blue);
        if (o_half_bright != want.half)
            flag_mismatch("half_bright", o_half_bright, want.half);
        if (o_chosen_slot != want.slot)
            flag_mismatch("chosen_slot", o_chosen_slot, want.slot);
        if (o_matched != want.matched)
            flag_mismatch("matched", o_matched, want.matched);
        if (o_best_distance != want.sq_dist)
            flag_mismatch("best_distance", o_best_distance, want.sq_dist);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                check_result();
            if (hold_request) begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < sink_stall_pct);
            end
        end
    end

    // Watchdog: any accepted beat on either side restarts the count.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("** ehb_nearest_palette_mapper: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every slot has to be written before the first map beat: start black.
    task automatic test_palette_fill();
        for (int s = 0; s < PAL_SIZE; s++)
            load_entry(5'(s), 12'h000);
    endtask

    task automatic test_directed_cases();
        map_pixel(4'hF, 4'hF, 4'hF);        // all candidates at 675: no match
        map_pixel(4'hF, 4'h0, 4'h0);        // exactly 225 is not below the limit
        map_pixel(4'hE, 4'h0, 4'h0);        // 196, just inside the limit
        map_pixel(4'h0, 4'h0, 4'h0);        // 64-way tie, slot 0 full wins
        load_entry(5'd31, 12'hFFF);
        map_pixel(4'hF, 4'hF, 4'hF);        // exact hit on the last slot
        map_pixel(4'h8, 4'h8, 4'h8);        // halved white beats full white
        load_entry(5'd5, 12'h0F0);
        map_pixel(4'h0, 4'hF, 4'h0);        // pure green, full
        load_entry(5'd17, 12'h0F0);
        map_pixel(4'h0, 4'hF, 4'h0);        // duplicate later slot must lose
        map_pixel(4'h0, 4'h7, 4'h0);        // halved green, exact
        load_entry(5'd0, 12'hA5C);
        map_pixel(4'hC, 4'h5, 4'hA);        // channel order within the word
        map_pixel(4'h6, 4'h2, 4'h5);        // near the halved 0xA5C
    endtask

    // Mostly map beats against a palette that keeps drifting.
    task automatic test_random_traffic(int n);
        logic [11:0] color;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 25) begin
                case ($urandom_range(7))
                    0:       color = 12'h000;
                    1:       color = 12'hFFF;
                    default: color = 12'($urandom);
                endcase
                load_entry(5'($urandom_range(PAL_SIZE - 1)), color);
            end else begin
                map_pixel(4'($urandom), 4'($urandom), 4'($urandom));
            end
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // beats; the output register and the sequencer fill and o_stall rises.
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int k = 0; k < 24; k++) begin
            if (k % 4 == 3)
                load_entry(5'($urandom), 12'($urandom));
            else
                map_pixel(4'($urandom), 4'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_palette_fill();
        test_directed_cases();

        src_idle_pct = 0;  sink_stall_pct = 0;
        test_random_traffic(120);
        src_idle_pct = 73; sink_stall_pct = 0;
        test_random_traffic(120);
        src_idle_pct = 0;  sink_stall_pct = 73;
        test_random_traffic(120);
        src_idle_pct = 16; sink_stall_pct = 16;
        test_random_traffic(120);

        src_idle_pct = 0;  sink_stall_pct = 0;
        test_backpressure();

        i_valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge i_clk);
        // let any stray result beat show up before the verdict
        repeat (SEARCH_CYCLES + 10) @(posedge i_clk);

        if (error_count == 0)
            $display("** ehb_nearest_palette_mapper: PASSED **");
        else
            $display("** ehb_nearest_palette_mapper: FAILED **");
        $finish;
    end

endmodule
